// File: rtl/core/npc_pkg.sv
package npc_pkg;

  localparam int unsigned TableLen = 22;
  localparam int unsigned MaskW    = 22;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned DistW    = 10;  // 3 * 255 = 765 fits

  // Palette, entry i = {R, G, B}
  localparam logic [ChanW-1:0] PalR [TableLen] = '{
    8'd0,   8'd255, 8'd255, 8'd0,   8'd0,   8'd187, 8'd102, 8'd0,
    8'd0,   8'd191, 8'd0,   8'd146, 8'd34,  8'd64,  8'd128, 8'd128,
    8'd186, 8'd135, 8'd143, 8'd144, 8'd165, 8'd255
  };
  localparam logic [ChanW-1:0] PalG [TableLen] = '{
    8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd0,   8'd102, 8'd0,
    8'd128, 8'd255, 8'd255, 8'd211, 8'd139, 8'd224, 8'd0,   8'd0,
    8'd184, 8'd206, 8'd21,  8'd238, 8'd42,  8'd255
  };
  localparam logic [ChanW-1:0] PalB [TableLen] = '{
    8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd102, 8'd128,
    8'd128, 8'd0,   8'd255, 8'd202, 8'd34,  8'd208, 8'd0,   8'd128,
    8'd108, 8'd235, 8'd0,   8'd144, 8'd42,  8'd0
  };

  typedef struct packed {
    logic            vld;
    logic [DistW-1:0] cost;
    logic [IdxW-1:0]  idx;
  } cand_t;

  localparam cand_t NoCand = '{vld: 1'b0, cost: '0, idx: '0};

  function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // a must carry the lower index: it wins ties
  function automatic cand_t pick(input cand_t a, input cand_t b);
    if (a.vld && (!b.vld || (a.cost <= b.cost))) begin
      return a;
    end
    return b;
  endfunction

  function automatic cand_t pick4(input cand_t a, input cand_t b,
                                  input cand_t c, input cand_t d);
    return pick(pick(a, b), pick(c, d));
  endfunction

endpackage

// File: rtl/core/nearest_palette_color_unit.sv
// Channel   Handshake                         Payload
// ------    --------------------------------  ------------------------------
// pixel     pixel_valid_i / pixel_ready_o     pixel_word_i [31:0] (ffBBGGRR)
// result    result_valid_o / result_ready_i   color_index_o [4:0], none_enabled_o
// config    cfg_we_i (no wait)                cfg_wdata_i [21:0] -> enable mask
//
// Four register stages: distances, two 4:1 minimum levels, then the last
// 4:1 level into the output register. One item per cycle sustained while
// the result side is ready.
// Reset clears the stage valid bits and sets the enable mask to all ones.
// A stage holds while the one after it is full and stalled; ready is driven
// back stage by stage, so a stall loses and repeats nothing.
module nearest_palette_color_unit #(
  parameter int unsigned PALETTE_SIZE = 22
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [npc_pkg::MaskW-1:0] cfg_wdata_i,
  input  logic                      pixel_valid_i,
  output logic                      pixel_ready_o,
  input  logic [31:0]               pixel_word_i,
  output logic                      result_valid_o,
  input  logic                      result_ready_i,
  output logic [npc_pkg::IdxW-1:0]  color_index_o,
  output logic                      none_enabled_o
);
  import npc_pkg::*;

  // candidates: below both the palette size and the table length
  localparam int unsigned NumLanes = (PALETTE_SIZE < TableLen) ? PALETTE_SIZE : TableLen;
  localparam int unsigned N1 = (NumLanes + 3) / 4;
  localparam int unsigned N2 = (N1 + 3) / 4;

  logic [MaskW-1:0] enable_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_mask_q <= '1;
    end else if (cfg_we_i) begin
      enable_mask_q <= cfg_wdata_i;
    end
  end

  // stage valids and advance chain
  logic v1_q, v2_q, v3_q, vo_q;
  logic adv1, adv2, adv3, advo;

  assign advo = !vo_q || result_ready_i;
  assign adv3 = !v3_q || advo;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign pixel_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= pixel_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (advo) vo_q <= v3_q;
    end
  end

  // Stage 1: one Manhattan distance per palette lane
  cand_t s1_d [NumLanes];
  cand_t s1_q [NumLanes];

  always_comb begin : p_dist
    logic [ChanW-1:0] red, green, blue;
    red   = pixel_word_i[7:0];
    green = pixel_word_i[15:8];
    blue  = pixel_word_i[23:16];
    for (int i = 0; i < NumLanes; i++) begin
      s1_d[i].vld  = enable_mask_q[i];
      s1_d[i].idx  = IdxW'(i);
      s1_d[i].cost = DistW'(abs_diff(red, PalR[i]))
                   + DistW'(abs_diff(green, PalG[i]))
                   + DistW'(abs_diff(blue, PalB[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) s1_q <= s1_d;
  end

  // Stage 2: groups of four, kept in index order so ties go low
  cand_t s2_d [N1];
  cand_t s2_q [N1];

  always_comb begin : p_red1
    cand_t q [4];
    for (int g = 0; g < N1; g++) begin
      for (int j = 0; j < 4; j++) begin
        q[j] = NoCand;
        if (g * 4 + j < NumLanes) begin
          q[j] = s1_q[g * 4 + j];
        end
      end
      s2_d[g] = pick4(q[0], q[1], q[2], q[3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) s2_q <= s2_d;
  end

  // Stage 3
  cand_t s3_d [N2];
  cand_t s3_q [N2];

  always_comb begin : p_red2
    cand_t q [4];
    for (int g = 0; g < N2; g++) begin
      for (int j = 0; j < 4; j++) begin
        q[j] = NoCand;
        if (g * 4 + j < N1) begin
          q[j] = s2_q[g * 4 + j];
        end
      end
      s3_d[g] = pick4(q[0], q[1], q[2], q[3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) s3_q <= s3_d;
  end

  // Output stage: last level; nothing enabled gives index 0 and the flag
  cand_t fin;
  logic [IdxW-1:0] color_index_q;
  logic            none_enabled_q;

  always_comb begin : p_red3
    cand_t q [4];
    for (int j = 0; j < 4; j++) begin
      q[j] = NoCand;
      if (j < N2) begin
        q[j] = s3_q[j];
      end
    end
    fin = pick4(q[0], q[1], q[2], q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (advo) begin
      color_index_q  <= fin.vld ? fin.idx : '0;
      none_enabled_q <= !fin.vld;
    end
  end

  assign result_valid_o = vo_q;
  assign color_index_o  = color_index_q;
  assign none_enabled_o = none_enabled_q;

  // Checks
  a_none_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && none_enabled_o |-> color_index_o == '0)
    else $error("none_enabled with nonzero index");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> 32'(color_index_o) < NumLanes)
    else $error("color index beyond palette");

  a_idx_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !none_enabled_o |-> enable_mask_q[color_index_o])
    else $error("chosen color is masked off");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q && !v2_q && !v3_q && !vo_q |-> pixel_ready_o)
    else $error("empty pipeline refuses items");

endmodule

// File: verif/nearest_palette_color_unit_tb.sv
`timescale 1ns / 100ps

module nearest_palette_color_unit_tb;
  import npc_pkg::*;

  // Candidate count: the block default, which matches the palette table
  localparam int unsigned NumColors = 22;
  // Random part: segments of items, one enable mask per segment
  localparam int unsigned NumSegments = 9;
  localparam int unsigned SegItems = 214;
  // Pipeline depth is 4; a few spare cycles before any mask write or the end
  localparam int unsigned DrainCycles = 8;
  // Watchdog limit; even at 82% stall the whole run stays far below it
  localparam int unsigned CycleLimit = 200000;

  // One expected result: nearest color and the no-color flag
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            none;
  } palette_pick_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [MaskW-1:0]     cfg_wdata_i = '0;
  logic                 pixel_valid_i = 1'b0;
  logic                 pixel_ready_o;
  logic [31:0]          pixel_word_i = '0;
  logic                 result_valid_o;
  logic                 result_ready_i = 1'b0;
  logic [IdxW-1:0]      color_index_o;
  logic                 none_enabled_o;

  // Pixels waiting for the driver, and picks waiting for the block to answer
  logic [31:0]          pending_pixels_q[$];
  palette_pick_t        expected_picks_q[$];

  // Local copy of the enable mask; only changed while the pipe is empty
  logic [MaskW-1:0]     enable_mask_copy = {MaskW{1'b1}};

  // Idle odds in percent, per side
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_idle_pct = 0;

  int unsigned          error_cnt = 0;
  int unsigned          checked_cnt = 0;
  int unsigned          none_cnt = 0;
  int unsigned          mask_writes = 0;
  int unsigned          cycle_cnt = 0;
  palette_pick_t        want;

  nearest_palette_color_unit #(
    .PALETTE_SIZE(NumColors)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_word_i  (pixel_word_i),
    .result_valid_o(result_valid_o),
    .result_ready_i(result_ready_i),
    .color_index_o (color_index_o),
    .none_enabled_o(none_enabled_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic int unsigned chan_gap(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // Manhattan distance over R, G, B; alpha ignored. Strict less-than keeps
  // the lowest index on a tie. No enabled color: index 0 with the flag up.
  function automatic palette_pick_t nearest_enabled_color(input logic [31:0] px,
                                                         input logic [MaskW-1:0] en);
    palette_pick_t res;
    int unsigned   best;
    int unsigned   d;
    bit            hit;
    res  = '{idx: '0, none: 1'b1};
    best = 0;
    hit  = 1'b0;
    for (int i = 0; i < NumColors && i < TableLen; i++) begin
      if (en[i]) begin
        d = chan_gap(px[7:0], PalR[i]) + chan_gap(px[15:8], PalG[i])
            + chan_gap(px[23:16], PalB[i]);
        if (!hit || d < best) begin
          hit     = 1'b1;
          best    = d;
          res.idx = IdxW'(i);
        end
      end
    end
    res.none = !hit;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Palette channel moved by up to 4 steps, clamped to the byte
  function automatic logic [7:0] nudge(input logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(8)) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Mix of fully random words, near-palette colors (close calls), midpoints
  // between two palette entries (likely ties) and saturated channels.
  function automatic logic [31:0] random_pixel();
    logic [7:0]  a, r, g, b;
    int unsigned k, j;
    a = 8'($urandom);
    k = $urandom_range(TableLen - 1);
    j = $urandom_range(TableLen - 1);
    case ($urandom_range(3))
      0: begin
        return $urandom;
      end
      1: begin
        r = nudge(PalR[k]);
        g = nudge(PalG[k]);
        b = nudge(PalB[k]);
      end
      2: begin
        r = 8'((int'(PalR[k]) + int'(PalR[j])) / 2);
        g = 8'((int'(PalG[k]) + int'(PalG[j])) / 2);
        b = 8'((int'(PalB[k]) + int'(PalB[j])) / 2);
      end
      default: begin
        r = ($urandom_range(2) == 0) ? 8'h00 : ($urandom_range(1) ? 8'hFF : 8'($urandom));
        g = ($urandom_range(2) == 0) ? 8'h00 : ($urandom_range(1) ? 8'hFF : 8'($urandom));
        b = ($urandom_range(2) == 0) ? 8'h00 : ($urandom_range(1) ? 8'hFF : 8'($urandom));
      end
    endcase
    return {a, b, g, r};
  endfunction

  // Block until every queued pixel went in and every pick came out,
  // then let the pipe settle. Checked at the falling edge so the
  // driver's and monitor's updates from the rising edge have landed.
  task automatic wait_drained();
    while (pending_pixels_q.size() != 0 || pixel_valid_i || expected_picks_q.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mask writes only happen with the pipe empty
  task automatic program_enable_mask(input logic [MaskW-1:0] m);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    enable_mask_copy = m;
    mask_writes++;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Pixel driver: offers the next pending pixel when the slot frees up, idling at random.
  // Expected pick is computed at acceptance, with the mask then in force.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_valid_i <= 1'b0;
    end else begin
      if (pixel_valid_i && pixel_ready_o) begin
        expected_picks_q.push_back(nearest_enabled_color(pixel_word_i, enable_mask_copy));
      end
      // Slot is free when nothing is offered or the offer was just taken
      if (!pixel_valid_i || pixel_ready_o) begin
        if (pending_pixels_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pixel_valid_i <= 1'b1;
          pixel_word_i  <= pending_pixels_q.pop_front();
        end else begin
          pixel_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: compares each accepted item against the oldest pick,
  // and stalls the output side at random.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ready_i <= 1'b0;
    end else begin
      if (result_valid_o && result_ready_i) begin
        if (expected_picks_q.size() == 0) begin
          error_cnt++;
          $display("%0t: unexpected result, color_index %0d none_enabled %0b",
                   $time, color_index_o, none_enabled_o);
        end else begin
          want = expected_picks_q.pop_front();
          checked_cnt++;
          if (want.none) none_cnt++;
          if (color_index_o !== want.idx) begin
            error_cnt++;
            $display("%0t: color_index mismatch, expected %0d actual %0d",
                     $time, want.idx, color_index_o);
          end
          if (none_enabled_o !== want.none) begin
            error_cnt++;
            $display("%0t: none_enabled mismatch, expected %0b actual %0b",
                     $time, want.none, none_enabled_o);
          end
        end
      end
      result_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: reset, directed pixels on the reset mask, then random
  // segments, each under its own mask. Idle profile changes every three
  // segments: sender light/receiver heavy, then swapped, then none.
  // ---------------------------------------------------------------------
  initial begin
    logic [MaskW-1:0] seg_mask;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 9;
    recv_idle_pct = 82;

    // Directed: all-zero and all-one words, every palette color exactly
    // (distance 0, alpha flipping), and a mid-gray that sits near several.
    pending_pixels_q.push_back(32'h0000_0000);
    pending_pixels_q.push_back(32'hFFFF_FFFF);
    for (int i = 0; i < TableLen; i++)
      pending_pixels_q.push_back({(i % 2 == 0) ? 8'hFF : 8'h00, PalB[i], PalG[i], PalR[i]});
    pending_pixels_q.push_back(32'h7F80_817F);

    for (int s = 0; s < NumSegments; s++) begin
      case (s)
        0: seg_mask = {MaskW{1'b1}};                       // all colors
        1: seg_mask = '0;                                  // nothing enabled
        2: seg_mask = MaskW'(1) << (MaskW - 1);            // top entry only
        3: seg_mask = MaskW'(1);                           // entry 0 only
        5: seg_mask = 22'h15_5555;
        6: seg_mask = 22'h2A_AAAA;
        8: seg_mask = MaskW'($urandom) & MaskW'($urandom) & MaskW'($urandom); // sparse
        default: seg_mask = MaskW'($urandom);
      endcase
      program_enable_mask(seg_mask);
      case (s / 3)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < SegItems; n++)
        pending_pixels_q.push_back(random_pixel());
    end

    wait_drained();

    if (expected_picks_q.size() != 0) begin
      error_cnt += expected_picks_q.size();
      $display("%0t: %0d expected results never arrived", $time, expected_picks_q.size());
    end

    $display("Checked %0d nearest-color results (%0d with no color enabled)",
             checked_cnt, none_cnt);
    $display("across %0d enable-mask writes and three stall profiles", mask_writes);
    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
